### src/lse_pkg.sv
`timescale 1ns / 1ps

package lse_pkg;

	// Field widths and default stack depth
	localparam int DATA_W    = 32;
	localparam int LIMIT_W   = 7;
	localparam int DEPTH_DEF = 64;

	// Limit register value after reset
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// Request kinds, encoded as on the req_type port
	typedef enum logic [1:0] {
		OP_PUSH     = 2'd0,
		OP_POP      = 2'd1,
		OP_TRAVERSE = 2'd2,
		OP_PEEK     = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Back end sequencer states
	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_READ = 1'b1
	} back_state_t;

	// Command word passed from front to back
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] value;
	} cmd_t;

endpackage

### src/lifo_stack_engine.sv
`timescale 1ns / 1ps

// LIFO stack of signed 32-bit words, up to DEPTH entries, usable size set by
// the limit register (written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, the block itself does not enforce this). A request
// is taken when start is high and busy is low; a two-word command queue sits
// in front of the execution unit, so busy rises only when that queue is full.
// Results appear for exactly one cycle with done high and the receiver cannot
// stall them. A push, a full push or any empty result is given in the cycle the
// command reaches the execution unit; pop, peek and traverse words come from
// the registered read port of the stack memory, and a traverse gives one word
// per cycle after the first.

module lifo_stack_engine import lse_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [LIMIT_W-1:0]       cfg_wr_data,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               req_type,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] data_value,
	output logic                     last
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// request intake and queue
	lse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.push_value (push_value),
		.busy       (busy),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	// stack memory and execution
	lse_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.done        (done),
		.status      (status),
		.data_value  (data_value),
		.last        (last)
	);

endmodule

### src/lse_front.sv
`timescale 1ns / 1ps

module lse_front import lse_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               req_type,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     busy,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  logic                     cmd_pop
);

	// two-word command queue
	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       accept;
	cmd_t       new_cmd;

	// classify the request into a command word
	always_comb begin
		new_cmd.op    = op_t'(req_type);
		new_cmd.value = push_value;
	end

	assign busy      = (fill_q == 2'd2);
	assign accept    = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (accept && !cmd_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!accept && cmd_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

### src/lse_back.sv
`timescale 1ns / 1ps

module lse_back import lse_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [LIMIT_W-1:0]       cfg_wr_data,
	input  logic                     cmd_valid,
	input  cmd_t                     cmd,
	output logic                     cmd_pop,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] data_value,
	output logic                     last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	back_state_t        state_q, state_d;
	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic               trav_q;
	logic [DATA_W-1:0]  mem [DEPTH];
	logic [DATA_W-1:0]  rd_q;

	logic          is_full;
	logic          is_empty;
	logic [CW-1:0] top_cnt;
	logic [AW-1:0] top_idx;
	logic          rd_last;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          cnt_inc;
	logic          cnt_dec;
	logic          start_read;

	// occupancy checks
	assign is_full  = (LIMIT_W'(count_q) >= limit_q) || (count_q >= DEPTH_C);
	assign is_empty = (count_q == '0);
	assign top_cnt  = count_q - 1'b1;
	assign top_idx  = top_cnt[AW-1:0];
	assign rd_last  = !(trav_q && (idx_q != '0));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && (cmd.op != OP_PUSH) && !is_empty) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (rd_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		cmd_pop    = 1'b0;
		done       = 1'b0;
		status     = ST_OK;
		data_value = '0;
		last       = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = top_idx;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		start_read = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_PUSH) begin
						done = 1'b1;
						last = 1'b1;
						if (is_full) begin
							status = ST_FULL;
						end else begin
							wr_en   = 1'b1;
							cnt_inc = 1'b1;
						end
					end else if (is_empty) begin
						done   = 1'b1;
						last   = 1'b1;
						status = ST_EMPTY;
					end else begin
						// pop, peek or traverse: fetch the top entry first
						rd_en      = 1'b1;
						start_read = 1'b1;
						cnt_dec    = (cmd.op == OP_POP);
					end
				end
			end
			BK_READ: begin
				done       = 1'b1;
				data_value = rd_q;
				last       = rd_last;
				if (!rd_last) begin
					rd_en   = 1'b1;
					rd_addr = idx_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// stack memory, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= cmd.value;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			limit_q <= LIMIT_RESET;
			count_q <= '0;
			idx_q   <= '0;
			trav_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cnt_dec) begin
				count_q <= top_cnt;
			end
			if (start_read) begin
				idx_q  <= top_idx;
				trav_q <= (cmd.op == OP_TRAVERSE);
			end else if (rd_en) begin
				idx_q <= rd_addr;
			end
		end
	end

endmodule

### sim/lifo_stack_engine_test.sv
`timescale 1ns / 1ps

module lifo_stack_engine_test;
	import lse_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int MAX_REPORTS = 10;

	// One result word as seen on the output ports
	typedef struct packed {
		status_t           st;
		logic [DATA_W-1:0] data;
		logic              is_last;
	} word_t;

	// One line of the directed script: a limit write or a request
	typedef struct packed {
		bit                 is_cfg;
		logic [LIMIT_W-1:0] lim;
		op_t                op;
		logic [DATA_W-1:0]  val;
		bit                 typed;
		word_t              want;
	} row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [LIMIT_W-1:0]       cfg_wr_data;
	logic                     start;
	logic                     busy;
	logic [1:0]               req_type;
	logic signed [DATA_W-1:0] push_value;
	logic                     done;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] data_value;
	logic                     last;

	lifo_stack_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.push_value  (push_value),
		.done        (done),
		.status      (status),
		.data_value  (data_value),
		.last        (last)
	);

	// Stack shadow
	logic [DATA_W-1:0]  stack_mem [DEPTH_DEF];
	int                 depth_now;
	logic [LIMIT_W-1:0] limit_reg;

	word_t pending_words [$];
	word_t fresh_words [$];
	row_t  script [$];

	int requests_sent;
	int words_checked;
	int mismatch_count;
	int full_seen;
	int empty_seen;
	int deepest;
	int stall_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic word_t make_word(status_t st, logic [DATA_W-1:0] data, logic fin);
		word_t w;
		w.st = st;
		w.data = data;
		w.is_last = fin;
		return w;
	endfunction

	// Works out the words one request yields and updates the shadow stack
	function automatic void stack_predict(op_t op, logic [DATA_W-1:0] val);
		int eff;
		int k;
		fresh_words.delete();
		eff = (limit_reg > DEPTH_DEF) ? DEPTH_DEF : int'(limit_reg);
		if (op == OP_PUSH) begin
			if (depth_now >= eff) begin
				fresh_words.push_back(make_word(ST_FULL, '0, 1'b1));
				full_seen++;
			end else begin
				stack_mem[depth_now] = val;
				depth_now++;
				if (depth_now > deepest)
					deepest = depth_now;
				fresh_words.push_back(make_word(ST_OK, '0, 1'b1));
			end
		end else if (depth_now == 0) begin
			fresh_words.push_back(make_word(ST_EMPTY, '0, 1'b1));
			empty_seen++;
		end else begin
			case (op)
				OP_POP: begin
					depth_now--;
					fresh_words.push_back(make_word(ST_OK, stack_mem[depth_now], 1'b1));
				end
				OP_PEEK: begin
					fresh_words.push_back(make_word(ST_OK, stack_mem[depth_now-1], 1'b1));
				end
				default: begin
					// traverse, top first
					for (k = depth_now - 1; k >= 0; k--)
						fresh_words.push_back(make_word(ST_OK, stack_mem[k], k == 0));
				end
			endcase
		end
	endfunction

	// Script builders
	function automatic void add_req(op_t op, logic [DATA_W-1:0] val);
		row_t r;
		r = '0;
		r.op = op;
		r.val = val;
		script.push_back(r);
	endfunction

	function automatic void add_check(op_t op, logic [DATA_W-1:0] val, status_t st,
			logic [DATA_W-1:0] data);
		row_t r;
		r = '0;
		r.op = op;
		r.val = val;
		r.typed = 1'b1;
		r.want = make_word(st, data, 1'b1);
		script.push_back(r);
	endfunction

	function automatic void add_cfg(logic [LIMIT_W-1:0] lim);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.lim = lim;
		script.push_back(r);
	endfunction

	// Present one request and hold it until the handshake; start stays high
	task automatic send_request(op_t op, logic [DATA_W-1:0] val, bit typed, word_t want);
		start <= 1'b1;
		req_type <= op;
		push_value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		stack_predict(op, val);
		if (typed)
			pending_words.push_back(want);
		else
			foreach (fresh_words[i])
				pending_words.push_back(fresh_words[i]);
		requests_sent++;
	endtask

	task automatic idle_gap(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] lim);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_reg = lim;
	endtask

	function automatic op_t pick_op(int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct)
			return OP_PUSH;
		r = $urandom_range(9);
		if (r < 5)
			return OP_POP;
		if (r < 8)
			return OP_PEEK;
		return OP_TRAVERSE;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Result checker: every done word against the oldest expectation
	always @(posedge clk) begin : check_words
		word_t want;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected word: status %0d data %h last %0d",
						status, data_value, last);
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (status !== want.st || data_value !== want.data ||
						last !== want.is_last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("word %0d: exp status %0d data %h last %0d, got %0d %h %0d",
							words_checked, want.st, want.data, want.is_last,
							status, data_value, last);
				end
			end
		end
	end

	// Watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles = 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("lifo_stack_engine regression: fail");
			$finish;
		end else begin
			stall_cycles++;
		end
	end

	// Stimulus
	initial begin : stimulus
		int phase_items [5];
		int phase_push [5];
		int phase_idle [5];
		int phase_lim [5];
		int p;
		int i;
		row_t r;

		phase_items = '{80, 60, 30, 50, 50};
		phase_push  = '{95, 20, 50, 30, 55};
		phase_idle  = '{0, 77, 16, 0, 77};
		phase_lim   = '{127, 5, 0, 64, -1};

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		start <= 1'b0;
		req_type <= OP_PUSH;
		push_value <= '0;
		depth_now = 0;
		limit_reg = LIMIT_RESET;
		requests_sent = 0;
		words_checked = 0;
		mismatch_count = 0;
		full_seen = 0;
		empty_seen = 0;
		deepest = 0;
		stall_cycles = 0;
		for (i = 0; i < DEPTH_DEF; i++)
			stack_mem[i] = '0;

		// Directed script: empty cases, extremes, limit corners
		add_check(OP_POP,      32'h0,         ST_EMPTY, 32'h0);
		add_check(OP_PEEK,     32'hffff_ffff, ST_EMPTY, 32'h0);
		add_check(OP_TRAVERSE, 32'h0,         ST_EMPTY, 32'h0);
		add_check(OP_PUSH,     32'h7fff_ffff, ST_OK,    32'h0);
		add_check(OP_PUSH,     32'h8000_0000, ST_OK,    32'h0);
		add_check(OP_PEEK,     32'h0,         ST_OK,    32'h8000_0000);
		add_req(OP_TRAVERSE, 32'h0);
		add_check(OP_PUSH,     32'h0,         ST_OK,    32'h0);
		add_check(OP_PUSH,     32'hffff_ffff, ST_OK,    32'h0);
		// limit dropped below the held count
		add_cfg(7'd2);
		add_check(OP_PUSH,     32'h1234_5678, ST_FULL,  32'h0);
		add_req(OP_TRAVERSE, 32'h0);
		add_req(OP_POP, 32'h0);
		add_req(OP_POP, 32'h0);
		add_req(OP_POP, 32'h0);
		add_req(OP_POP, 32'h0);
		add_check(OP_POP,      32'h0,         ST_EMPTY, 32'h0);
		// zero limit refuses every push
		add_cfg(7'd0);
		add_check(OP_PUSH,     32'hdead_beef, ST_FULL,  32'h0);
		add_check(OP_PEEK,     32'h0,         ST_EMPTY, 32'h0);
		add_cfg(7'd1);
		add_check(OP_PUSH,     32'h55aa_55aa, ST_OK,    32'h0);
		add_check(OP_PUSH,     32'h0f0f_0f0f, ST_FULL,  32'h0);
		add_req(OP_POP, 32'h0);
		// limit above depth acts as depth
		add_cfg(7'd127);
		add_check(OP_PUSH,     32'haaaa_5555, ST_OK,    32'h0);
		add_req(OP_TRAVERSE, 32'h0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			r = script[k];
			if (r.is_cfg)
				write_limit(r.lim);
			else
				send_request(r.op, r.val, r.typed, r.want);
		end

		// Random phases: fill to depth, drain under a small limit, zero limit,
		// refill and empty, then small random limits
		for (p = 0; p < 5; p++) begin
			if (phase_lim[p] < 0)
				write_limit(LIMIT_W'($urandom_range(1, 8)));
			else
				write_limit(LIMIT_W'(phase_lim[p]));
			for (i = 0; i < phase_items[p]; i++) begin
				send_request(pick_op(phase_push[p]), pick_value(), 1'b0, '0);
				if (p == 1 && i == phase_items[p] / 2)
					wait_drained();
				else
					idle_gap(phase_idle[p]);
			end
		end

		wait_drained();
		repeat (DEPTH_DEF + 8) @(posedge clk);

		$display("ran %0d requests and checked %0d result words", requests_sent,
			words_checked);
		$display("saw %0d full and %0d empty reports, deepest stack %0d",
			full_seen, empty_seen, deepest);
		if (mismatch_count == 0 && pending_words.size() == 0) begin
			$display("lifo_stack_engine regression: pass");
		end else begin
			$display("%0d mismatches, %0d words still expected", mismatch_count,
				pending_words.size());
			$display("lifo_stack_engine regression: fail");
		end
		$finish;
	end

endmodule
